// ===== hw/rtl/rshf_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray segment hit fraction package
// Shared widths and defaults for the ray / segment hit fraction pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package rshf_pkg;
    localparam int IN_W              = 24;
    localparam int DIFF_W            = IN_W + 1;
    localparam int PROD_W            = 2 * DIFF_W;
    localparam int CROSS_W           = PROD_W + 1;
    localparam int TOL_SHIFT         = 8;
    // Coordinate fraction bits. The scale cancels in the hit ratios, so no
    // logic depends on it.
    localparam int COORD_FRAC_BITS   = 8;
    localparam int FRACTION_BITS_DEF = 16;
endpackage
`default_nettype wire

// ===== hw/rtl/rshf_cross.sv =====
// ----------------------------------------------------------------------------
// Ray segment hit fraction cross products
// Three register stages: differences, six products, three cross products.
// ----------------------------------------------------------------------------
`default_nettype none
module rshf_cross
    import rshf_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic signed [IN_W-1:0]      ax,
    input  wire logic signed [IN_W-1:0]      ay,
    input  wire logic signed [IN_W-1:0]      bx,
    input  wire logic signed [IN_W-1:0]      by,
    input  wire logic signed [IN_W-1:0]      px,
    input  wire logic signed [IN_W-1:0]      py,
    input  wire logic signed [IN_W-1:0]      mx,
    input  wire logic signed [IN_W-1:0]      my,
    output logic                             out_valid,
    output logic signed [CROSS_W-1:0]        d,
    output logic signed [CROSS_W-1:0]        tn,
    output logic signed [CROSS_W-1:0]        un
);
    logic [2:0] v_reg;
    logic signed [DIFF_W-1:0] ex_reg, ey_reg, wx_reg, wy_reg, mx_reg, my_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [CROSS_W-1:0] d_reg, tn_reg, un_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    // Differences, products, then cross products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg <= DIFF_W'(bx) - DIFF_W'(ax);
            ey_reg <= DIFF_W'(by) - DIFF_W'(ay);
            wx_reg <= DIFF_W'(ax) - DIFF_W'(px);
            wy_reg <= DIFF_W'(ay) - DIFF_W'(py);
            mx_reg <= DIFF_W'(mx);
            my_reg <= DIFF_W'(my);
            p0_reg <= ex_reg * my_reg;
            p1_reg <= ey_reg * mx_reg;
            p2_reg <= ex_reg * wy_reg;
            p3_reg <= ey_reg * wx_reg;
            p4_reg <= mx_reg * wy_reg;
            p5_reg <= my_reg * wx_reg;
            d_reg  <= CROSS_W'(p0_reg) - CROSS_W'(p1_reg);
            tn_reg <= CROSS_W'(p2_reg) - CROSS_W'(p3_reg);
            un_reg <= CROSS_W'(p4_reg) - CROSS_W'(p5_reg);
        end
    end

    assign out_valid = v_reg[2];
    assign d  = d_reg;
    assign tn = tn_reg;
    assign un = un_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/rshf_divide.sv =====
// ----------------------------------------------------------------------------
// Ray segment hit fraction classifier and divider
// Normalizes signs, classifies the hit, then runs one restoring division
// step per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rshf_divide
    import rshf_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic signed [CROSS_W-1:0]   d,
    input  wire logic signed [CROSS_W-1:0]   tn,
    input  wire logic signed [CROSS_W-1:0]   un,
    output logic                             out_valid,
    output logic [FRACTION_BITS:0]           frac,
    output logic                             faces
);
    localparam int ST = FRACTION_BITS + 2;
    localparam int MAG_W = CROSS_W;
    localparam int TL_W = CROSS_W + TOL_SHIFT + 1;

    logic [ST-1:0] v_reg;

    // Stage A: sign normalization.
    logic               fa_reg, za_reg;
    logic signed [CROSS_W:0] da_reg, ta_reg, ua_reg;
    // Stage B: classification.
    logic [1:0]         cls_reg [ST-1];
    logic               fc_reg [ST-1];
    logic [MAG_W-1:0]   den_reg [ST-1];
    logic [MAG_W:0]     rem_reg [ST-1];
    logic [FRACTION_BITS-1:0] q_reg [ST-1];

    localparam logic [1:0] CLS_ONE  = 2'd0;
    localparam logic [1:0] CLS_ZERO = 2'd1;
    localparam logic [1:0] CLS_DIV  = 2'd2;

    logic signed [TL_W-1:0] tol;
    logic [1:0] cls_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ST-2:0], in_valid};
        end
    end

    // Negate all three when the denominator is negative.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fa_reg <= d[CROSS_W-1];
            za_reg <= (d == '0);
            da_reg <= d[CROSS_W-1] ? -(CROSS_W+1)'(d)  : (CROSS_W+1)'(d);
            ta_reg <= d[CROSS_W-1] ? -(CROSS_W+1)'(tn) : (CROSS_W+1)'(tn);
            ua_reg <= d[CROSS_W-1] ? -(CROSS_W+1)'(un) : (CROSS_W+1)'(un);
        end
    end

    // Classify against the segment range and the ray tolerance.
    always_comb
    begin
        tol = (TL_W'(ta_reg) <<< TOL_SHIFT) + TL_W'(da_reg);
        if (za_reg || ua_reg < 0 || ua_reg > da_reg || tol < 0)
        begin
            cls_next = CLS_ONE;
        end
        else if (ta_reg <= 0)
        begin
            cls_next = CLS_ZERO;
        end
        else if (ta_reg >= da_reg)
        begin
            cls_next = CLS_ONE;
        end
        else
        begin
            cls_next = CLS_DIV;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_reg[0] <= cls_next;
            fc_reg[0]  <= fa_reg;
            den_reg[0] <= MAG_W'(da_reg);
            rem_reg[0] <= (MAG_W+1)'(ta_reg);
            q_reg[0]   <= '0;
        end
    end

    // One quotient bit per stage.
    for (genvar g = 1; g < ST - 1; g++)
    begin : g_step
        logic [MAG_W+1:0] sh;
        logic [MAG_W+1:0] diff;
        assign sh   = {rem_reg[g-1], 1'b0};
        assign diff = sh - (MAG_W+2)'(den_reg[g-1]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cls_reg[g] <= cls_reg[g-1];
                fc_reg[g]  <= fc_reg[g-1];
                den_reg[g] <= den_reg[g-1];
                if (!diff[MAG_W+1])
                begin
                    rem_reg[g] <= diff[MAG_W:0];
                    q_reg[g]   <= {q_reg[g-1][FRACTION_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g] <= sh[MAG_W:0];
                    q_reg[g]   <= {q_reg[g-1][FRACTION_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        case (cls_reg[ST-2])
            CLS_ZERO: frac = '0;
            CLS_DIV:  frac = {1'b0, q_reg[ST-2]};
            default:  frac = {1'b1, {FRACTION_BITS{1'b0}}};
        endcase
    end

    assign faces     = fc_reg[ST-2];
    assign out_valid = v_reg[ST-1];
endmodule
`default_nettype wire

// ===== hw/rtl/ray_segment_hit_fraction.sv =====
// Stages: cross products, sign normalization, classification, divider, output register.
// Throughput: one transaction per cycle; a stalled full output register holds the whole pipe.
// Depth is set by the one-bit-per-stage restoring divider.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// Ray segment hit fraction
// Pipelined ray / segment intersection with clamped hit fraction output.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_segment_hit_fraction
    import rshf_pkg::*;
#(
    parameter int FRACTION_BITS   = FRACTION_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic signed [IN_W-1:0] seg_start_x,
    input  wire logic signed [IN_W-1:0] seg_start_y,
    input  wire logic signed [IN_W-1:0] seg_end_x,
    input  wire logic signed [IN_W-1:0] seg_end_y,
    input  wire logic signed [IN_W-1:0] pos_x,
    input  wire logic signed [IN_W-1:0] pos_y,
    input  wire logic signed [IN_W-1:0] move_x,
    input  wire logic signed [IN_W-1:0] move_y,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [FRACTION_BITS:0]      hit_fraction,
    output logic                        faces_motion
);
    logic en;
    logic cv;
    logic signed [CROSS_W-1:0] d, tn, un;
    logic dv;
    logic [FRACTION_BITS:0] frac;
    logic faces;
    logic out_valid_reg;
    logic [FRACTION_BITS:0] frac_reg;
    logic faces_reg;

    // The pipe advances whenever the output register is empty or draining.
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    rshf_cross u_cross (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .ax(seg_start_x), .ay(seg_start_y), .bx(seg_end_x), .by(seg_end_y),
        .px(pos_x), .py(pos_y), .mx(move_x), .my(move_y),
        .out_valid(cv), .d(d), .tn(tn), .un(un)
    );

    rshf_divide #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(cv),
        .d(d), .tn(tn), .un(un),
        .out_valid(dv), .frac(frac), .faces(faces)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac_reg  <= frac;
            faces_reg <= faces;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit_fraction = frac_reg;
    assign faces_motion = faces_reg;
endmodule
`default_nettype wire

// ===== tb/tb_ray_segment_hit_fraction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray segment hit fraction testbench
// Drives segment, ray start and motion vectors into the block with random
// idle and stall cycles. An internal model predicts each hit fraction and
// facing flag, and every output transaction is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_ray_segment_hit_fraction;
    import rshf_pkg::*;

    localparam int FB        = FRACTION_BITS_DEF;
    localparam int LIMIT     = 400000;
    localparam int N_RANDOM  = 1270;
    localparam logic [FB:0] FRAC_ONE = {1'b1, {FB{1'b0}}};

    typedef logic signed [IN_W-1:0] coord_t;

    typedef struct packed {
        logic [FB:0] frac;
        logic        faces;
    } hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    coord_t ax = '0, ay = '0, bx = '0, by = '0, px = '0, py = '0, mx = '0, my = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [FB:0] hit_fraction;
    logic faces_motion;

    hit_t expected_hits[$];
    int errors = 0;
    int checked = 0;
    int cycles = 0;
    int hit_count = 0;
    bit hold_recv = 1'b0;
    bit quiet_recv = 1'b0;
    bit quiet_send = 1'b0;

    ray_segment_hit_fraction DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .seg_start_x(ax), .seg_start_y(ay), .seg_end_x(bx), .seg_end_y(by),
        .pos_x(px), .pos_y(py), .move_x(mx), .move_y(my),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit_fraction(hit_fraction), .faces_motion(faces_motion)
    );

    always #5 clk = ~clk;

    // Predict the clamped hit fraction and facing flag from exact cross products.
    function automatic hit_t predict_hit(coord_t sax, coord_t say, coord_t sbx, coord_t sby,
                                         coord_t rpx, coord_t rpy, coord_t rmx, coord_t rmy);
        longint ex, ey, wx, wy, den, tnum, unum;
        longint rem, q;
        hit_t h;
        ex = longint'(sbx) - longint'(sax);
        ey = longint'(sby) - longint'(say);
        wx = longint'(sax) - longint'(rpx);
        wy = longint'(say) - longint'(rpy);
        den = ex * longint'(rmy) - ey * longint'(rmx);
        tnum = ex * wy - ey * wx;
        unum = longint'(rmx) * wy - longint'(rmy) * wx;
        h.faces = (den < 0);
        h.frac = FRAC_ONE;
        if (den != 0) begin
            if (den < 0) begin
                den = -den;
                tnum = -tnum;
                unum = -unum;
            end
            if (unum < 0 || unum > den || tnum * (longint'(1) << TOL_SHIFT) + den < 0)
                h.frac = FRAC_ONE;
            else if (tnum <= 0)
                h.frac = '0;
            else if (tnum >= den)
                h.frac = FRAC_ONE;
            else begin
                // Restoring long division, one quotient bit per step.
                rem = tnum;
                q = 0;
                for (int i = 0; i < FB; i++) begin
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= den) begin
                        rem = rem - den;
                        q = q | 1;
                    end
                end
                h.frac = q[FB:0];
            end
        end
        return h;
    endfunction

    // Offer one transaction, with random idle cycles, and hold it until accepted.
    // Valid stays high afterwards; the caller drops it when it has nothing more.
    task automatic send_segment(coord_t sax, coord_t say, coord_t sbx, coord_t sby,
                                coord_t rpx, coord_t rpy, coord_t rmx, coord_t rmy);
        while (!quiet_send && $urandom_range(99) < 12) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        ax <= sax; ay <= say; bx <= sbx; by <= sby;
        px <= rpx; py <= rpy; mx <= rmx; my <= rmy;
        expected_hits.insert(expected_hits.size(),
                             predict_hit(sax, say, sbx, sby, rpx, rpy, rmx, rmy));
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic coord_t rand_coord(int span);
        if (span == 0) return coord_t'($urandom);
        return coord_t'($urandom_range(2 * span) - span);
    endfunction

    // Directed corners: extremes, parallel, outside u, negative t, tolerance, t >= 1.
    task automatic test_directed();
        coord_t mxv, mnv;
        mxv = coord_t'(24'h7fffff);
        mnv = coord_t'(24'h800000);
        // Parallel and degenerate segments.
        send_segment(0, 0, 256, 0, 0, 10, 512, 0);
        send_segment(5, 5, 5, 5, 0, 0, 100, 100);
        send_segment(0, 0, 0, 0, 0, 0, 0, 0);
        // Clean hit at half the motion, both winding directions.
        send_segment(256, -256, 256, 256, 0, 0, 512, 0);
        send_segment(256, 256, 256, -256, 0, 0, 512, 0);
        // Segment parameter outside the segment on either side.
        send_segment(256, 10, 256, 256, 0, 0, 512, 0);
        send_segment(256, -256, 256, -10, 0, 0, 512, 0);
        // Endpoints exactly on the ray.
        send_segment(256, 0, 256, 256, 0, 0, 512, 0);
        send_segment(256, -256, 256, 0, 0, 0, 512, 0);
        // Ray parameter far behind, just within and just outside tolerance, and exactly zero.
        send_segment(-256, -256, -256, 256, 0, 0, 512, 0);
        send_segment(-2, -256, -2, 256, 0, 0, 512, 0);
        send_segment(-3, -256, -3, 256, 0, 0, 512, 0);
        send_segment(0, -256, 0, 256, 0, 0, 512, 0);
        // Ray parameter at one, beyond, and just below one.
        send_segment(512, -256, 512, 256, 0, 0, 512, 0);
        send_segment(900, -256, 900, 256, 0, 0, 512, 0);
        send_segment(511, -256, 511, 256, 0, 0, 512, 0);
        // Field extremes.
        send_segment(mxv, mnv, mnv, mxv, mnv, mnv, mxv, mxv);
        send_segment(mnv, mnv, mxv, mxv, mxv, mnv, mnv, mxv);
        send_segment(mnv, mxv, mnv, mnv, mxv, 0, mnv, mnv);
        send_segment(mxv, mxv, mxv, mnv, mnv, mnv, mxv, mnv);
        send_segment(-1, -1, -1, -1, -1, -1, -1, -1);
        send_segment(mxv, mxv, mxv, mxv, mxv, mxv, mxv, mxv);
    endtask

    // Random tests: mostly geometry that crosses, some fully random noise.
    task automatic test_random(int count);
        coord_t sax, say, sbx, sby, rpx, rpy, rmx, rmy;
        int span;
        for (int i = 0; i < count; i++) begin
            quiet_send = (i >= 300 && i < 450);
            quiet_recv = (i >= 300 && i < 450);
            case ($urandom_range(9))
                0, 1: span = 0;
                2: span = 64;
                3, 4: span = 4096;
                default: span = 1 << ($urandom_range(8, 22));
            endcase
            if (span == 0 || $urandom_range(3) == 0) begin
                sax = rand_coord(span); say = rand_coord(span);
                sbx = rand_coord(span); sby = rand_coord(span);
                rpx = rand_coord(span); rpy = rand_coord(span);
                rmx = rand_coord(span); rmy = rand_coord(span);
            end else begin
                // Segment straddling the ray path somewhere ahead or behind.
                rpx = rand_coord(span / 2); rpy = rand_coord(span / 2);
                rmx = rand_coord(span / 2); rmy = rand_coord(span / 2);
                sax = rpx + rand_coord(span / 2); say = rpy + rand_coord(span / 2);
                sbx = rpx + rmx - (sax - rpx) + rand_coord(span / 8);
                sby = rpy + rmy - (say - rpy) + rand_coord(span / 8);
            end
            send_segment(sax, say, sbx, sby, rpx, rpy, rmx, rmy);
        end
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
    endtask

    // Back-pressure: receiver holds off while the sender keeps offering.
    task automatic test_backpressure();
        hold_recv = 1'b1;
        for (int i = 0; i < 60; i++)
            send_segment(rand_coord(2048), rand_coord(2048), rand_coord(2048),
                         rand_coord(2048), rand_coord(2048), rand_coord(2048),
                         rand_coord(2048), rand_coord(2048));
    endtask

    // Receiver stall pattern.
    always @(negedge clk) begin
        if (!rst_n)
            out_stall <= 1'b1;
        else if (hold_recv)
            out_stall <= 1'b1;
        else
            out_stall <= !quiet_recv && ($urandom_range(99) < 12);
    end

    // Long hold-off counted here, then released by clearing hold_recv.
    initial begin
        int held;
        held = 0;
        forever begin
            @(posedge clk);
            if (hold_recv) begin
                held++;
                if (held >= 200) begin
                    hold_recv = 1'b0;
                    held = 0;
                end
            end
        end
    end

    // Check every output transaction against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_hits.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected output transaction: frac=%0d faces=%0b",
                                           hit_fraction, faces_motion);
            end else begin
                hit_t e;
                e = expected_hits.pop_front();
                checked++;
                if (e.frac != FRAC_ONE) hit_count++;
                if (e.frac !== hit_fraction || e.faces !== faces_motion) begin
                    errors++;
                    if (errors <= 10)
                        $display({"Mismatch %0d: expected frac=%0d faces=%0b, ",
                                  "got frac=%0d faces=%0b"},
                                 checked, e.frac, e.faces, hit_fraction, faces_motion);
                end
            end
        end
    end

    // Cycle limit watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_hits.size());
            $display("tb_ray_segment_hit_fraction: FAIL");
            $finish;
        end
    end

    initial begin
        int drain;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(N_RANDOM);
        in_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge clk);
        drain = 0;
        while (drain < 40) begin
            @(posedge clk);
            drain++;
        end
        $display("Checked %0d transactions (%0d real hits), including a 200-cycle output hold.",
                 checked, hit_count);
        if (errors == 0)
            $display("tb_ray_segment_hit_fraction: PASS");
        else begin
            $display("%0d mismatches", errors);
            $display("tb_ray_segment_hit_fraction: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
